[sv/krt_pkg.sv]
package krt_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int KEY_W    = 31;
    localparam int PAY_W    = 64;
    localparam int IDX_W    = 7;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_UPDATE   = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_READ_IDX = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADKEY   = 3'd1,
        STAT_DUP      = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [IDX_W-1:0] index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   found_key;
        logic [PAY_W-1:0]   found_payload;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

[sv/keyed_record_table.sv]
// A table of up to 128 records of a 31-bit key and a 64-bit payload, held in
// insertion order in a memory with one read and one write port that one key
// comparator walks through one entry at a time, reading it in S_RD and
// comparing it in S_CMP. Accepting a word, the block is busy until its result
// reaches the output register: a lookup walks from the first entry until a hit
// or the last entry held, an insert that misses then appends one more, a delete
// then moves the later entries down one place each, and a read at an index
// reads that one entry directly. Rejected words (zero key, full table, index
// beyond the count, unused opcode) go straight to the result. The next word is
// taken while a result still waits on the output side.
module keyed_record_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key[30:0], payload[94:31], index[101:95], zero fill[103:102]
    input  logic [103:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found_key[30:0], found_payload[94:31], entry_count[102:95], zero fill[103]
    output logic [103:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);
    import krt_pkg::*;

    req_t req;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_ready;

    logic m_tvalid_reg, m_tvalid_next;
    rsp_t out_reg, out_next;

    assign req.opcode  = s_tuser;
    assign req.key     = s_tdata[30:0];
    assign req.payload = s_tdata[94:31];
    assign req.index   = s_tdata[101:95];

    krt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (rsp_valid && rsp_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = rsp;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.entry_count, out_reg.found_payload, out_reg.found_key};

endmodule

[sv/krt_engine.sv]
module krt_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  krt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output krt_pkg::rsp_t rsp
);
    import krt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RD      = 8'b0000_0010,
        S_CMP     = 8'b0000_0100,
        S_APPEND  = 8'b0000_1000,
        S_SH_RD   = 8'b0001_0000,
        S_SH_WR   = 8'b0010_0000,
        S_IDX_OUT = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    entry_t mem [CAPACITY];

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    rsp_t              rsp_reg, rsp_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    entry_t            rd_data_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic [CNT_W:0]    ptr_inc;
    logic              more_after;
    logic              more_after2;
    logic [CNT_W-1:0]  fill_dec;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        ptr_reg <= ptr_next;
    end

    assign ptr_inc     = (CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(1);
    assign more_after  = ptr_inc < (CNT_W + 1)'(fill_reg);
    assign more_after2 = (ptr_inc + (CNT_W + 1)'(1)) < (CNT_W + 1)'(fill_reg);
    assign fill_dec    = fill_reg - CNT_W'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next                = req;
                    ptr_next                = '0;
                    rsp_next.status         = STAT_NOTFOUND;
                    rsp_next.found_key      = '0;
                    rsp_next.found_payload  = '0;
                    rsp_next.entry_count    = COUNT_W'(fill_reg);
                    state_next              = S_DONE;
                    case (opcode_t'(req.opcode))
                        OP_INSERT: begin
                            if (fill_reg == CNT_W'(CAPACITY)) begin
                                rsp_next.status = STAT_FULL;
                            end else if (req.key == '0) begin
                                rsp_next.status = STAT_BADKEY;
                            end else if (fill_reg == '0) begin
                                state_next = S_APPEND;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        OP_DELETE, OP_UPDATE, OP_LOOKUP: begin
                            if (req.key == '0) begin
                                rsp_next.status = STAT_BADKEY;
                            end else if (fill_reg != '0) begin
                                state_next = S_RD;
                            end
                        end
                        OP_READ_IDX: begin
                            if (32'(req.index) < 32'(fill_reg)) begin
                                ptr_next   = ADDR_W'(req.index);
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            rsp_next.status = STAT_NOTFOUND;
                        end
                    endcase
                end
            end
            S_RD: begin
                if (opcode_t'(req_reg.opcode) == OP_READ_IDX) begin
                    state_next = S_IDX_OUT;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_data_reg.key == req_reg.key) begin
                    rsp_next.found_key     = rd_data_reg.key;
                    rsp_next.found_payload = rd_data_reg.payload;
                    rsp_next.status        = STAT_OK;
                    state_next             = S_DONE;
                    case (opcode_t'(req_reg.opcode))
                        OP_INSERT: begin
                            rsp_next.status = STAT_DUP;
                        end
                        OP_DELETE: begin
                            if (more_after) begin
                                state_next = S_SH_RD;
                            end else begin
                                fill_next            = fill_dec;
                                rsp_next.entry_count = COUNT_W'(fill_dec);
                            end
                        end
                        OP_UPDATE: begin
                            wr_en           = 1'b1;
                            wr_data.key     = rd_data_reg.key;
                            wr_data.payload = req_reg.payload;
                        end
                        default: begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end else if (more_after) begin
                    ptr_next   = ADDR_W'(ptr_inc);
                    state_next = S_RD;
                end else if (opcode_t'(req_reg.opcode) == OP_INSERT) begin
                    state_next = S_APPEND;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_APPEND: begin
                wr_en                  = 1'b1;
                wr_addr                = ADDR_W'(fill_reg);
                wr_data.key            = req_reg.key;
                wr_data.payload        = req_reg.payload;
                fill_next              = fill_reg + CNT_W'(1);
                rsp_next.status        = STAT_OK;
                rsp_next.found_key     = req_reg.key;
                rsp_next.found_payload = req_reg.payload;
                rsp_next.entry_count   = COUNT_W'(fill_reg + CNT_W'(1));
                state_next             = S_DONE;
            end
            S_SH_RD: begin
                rd_addr    = ADDR_W'(ptr_inc);
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                wr_en    = 1'b1;
                ptr_next = ADDR_W'(ptr_inc);
                if (more_after2) begin
                    state_next = S_SH_RD;
                end else begin
                    fill_next            = fill_dec;
                    rsp_next.entry_count = COUNT_W'(fill_dec);
                    state_next           = S_DONE;
                end
            end
            S_IDX_OUT: begin
                rsp_next.status        = STAT_OK;
                rsp_next.found_key     = rd_data_reg.key;
                rsp_next.found_payload = rd_data_reg.payload;
                state_next             = S_DONE;
            end
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[tb/sv/keyed_record_table_tb.sv]
module keyed_record_table_tb;

    import krt_pkg::*;

    localparam int DATA_W          = 104;
    localparam int FIRST_UNUSED_OP = int'(OP_READ_IDX) + 1;
    localparam int LAST_UNUSED_OP  = (1 << OP_W) - 1;
    localparam int MAX_CYCLES      = 3_000_000;
    localparam int SETTLE_CYCLES   = 600;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;

    // Mirror of the record table and the queue of results it predicts.
    class table_scoreboard;
        logic [KEY_W-1:0] keys [CAPACITY];
        logic [PAY_W-1:0] pays [CAPACITY];
        int unsigned      fill;
        rsp_t             pending [$];
        int unsigned      mismatches;
        int unsigned      checked;

        function int locate(logic [KEY_W-1:0] key);
            for (int i = 0; i < fill; i++) begin
                if (keys[i] == key) begin
                    return i;
                end
            end
            return fill;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [PAY_W-1:0] pay, logic [IDX_W-1:0] idx);
            rsp_t want;
            int   pos;
            want        = '0;
            want.status = STAT_NOTFOUND;
            pos         = locate(key);
            case (op)
                OP_INSERT: begin
                    if (fill >= CAPACITY) begin
                        want.status = STAT_FULL;
                    end else if (key == '0) begin
                        want.status = STAT_BADKEY;
                    end else if (pos < fill) begin
                        want.status        = STAT_DUP;
                        want.found_key     = keys[pos];
                        want.found_payload = pays[pos];
                    end else begin
                        keys[fill]         = key;
                        pays[fill]         = pay;
                        fill++;
                        want.status        = STAT_OK;
                        want.found_key     = key;
                        want.found_payload = pay;
                    end
                end
                OP_DELETE, OP_UPDATE, OP_LOOKUP: begin
                    if (key == '0) begin
                        want.status = STAT_BADKEY;
                    end else if (pos < fill) begin
                        want.status        = STAT_OK;
                        want.found_key     = keys[pos];
                        want.found_payload = pays[pos];
                        if (op == OP_DELETE) begin
                            for (int j = pos; j + 1 < fill; j++) begin
                                keys[j] = keys[j+1];
                                pays[j] = pays[j+1];
                            end
                            fill--;
                        end else if (op == OP_UPDATE) begin
                            pays[pos] = pay;
                        end
                    end
                end
                OP_READ_IDX: begin
                    if (idx < fill) begin
                        want.status        = STAT_OK;
                        want.found_key     = keys[idx];
                        want.found_payload = pays[idx];
                    end
                end
                default: begin
                end
            endcase
            want.entry_count = COUNT_W'(fill);
            pending.push_back(want);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            bit   unexpected;
            bit   ok;
            want       = '0;
            unexpected = (pending.size() == 0);
            ok         = 1'b0;
            if (!unexpected) begin
                want = pending.pop_front();
                ok   = (got.status === want.status) && (got.found_key === want.found_key)
                    && (got.found_payload === want.found_payload)
                    && (got.entry_count === want.entry_count);
            end
            if (!ok) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    if (unexpected) begin
                        $display("Unexpected result word: status %0d key %h payload %h count %0d",
                                 got.status, got.found_key, got.found_payload, got.entry_count);
                    end else begin
                        $display("Result word %0d differs: status %0d/%0d key %h/%h", checked,
                                 want.status, got.status, want.found_key, got.found_key);
                        $display("    payload %h/%h count %0d/%0d (expected/actual)",
                                 want.found_payload, got.found_payload,
                                 want.entry_count, got.entry_count);
                    end
                end
            end
            checked++;
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]   s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    table_scoreboard sb = new();
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_len       = 0;
    int          hold_left      = 0;
    int unsigned cycles         = 0;

    keyed_record_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_side
        rsp_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = status_t'(m_tuser);
            got.found_key     = m_tdata[KEY_W-1:0];
            got.found_payload = m_tdata[KEY_W+PAY_W-1:KEY_W];
            got.entry_count   = m_tdata[KEY_W+PAY_W+COUNT_W-1:KEY_W+PAY_W];
            sb.check_result(got);
        end
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [PAY_W-1:0] pay, logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - IDX_W - PAY_W - KEY_W){1'b0}}, idx, pay, key};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_word(op, key, pay, idx);
    endtask

    task automatic send_random(int ins_pct, int del_pct);
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic [IDX_W-1:0] idx;
        int               r;
        int               hit_pct;
        int               k;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            op = OP_INSERT;
        end else if (r < ins_pct + del_pct) begin
            op = OP_DELETE;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: op = OP_UPDATE;
                5, 6, 7, 8, 9: op = OP_LOOKUP;
                15:            op = OP_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
                default:       op = OP_READ_IDX;
            endcase
        end
        hit_pct = (op == OP_INSERT) ? 10 : 75;
        k       = $urandom_range(0, 99);
        if (k < 4) begin
            key = '0;
        end else if (k < 4 + hit_pct && sb.fill > 0) begin
            key = sb.keys[$urandom_range(0, sb.fill - 1)];
        end else begin
            key = KEY_W'($urandom_range(32'h7fff_ffff, 1));
        end
        pay = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            idx = IDX_W'($urandom_range(0, sb.fill));
        end else begin
            idx = IDX_W'($urandom);
        end
        send_word(op, key, pay, idx);
    endtask

    task automatic wait_all_results();
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int phase_send [7] = '{0, 51, 0, 18, 0, 51, 0};
        int phase_recv [7] = '{0, 0, 51, 18, 0, 0, 51};
        int phase_ins  [7] = '{50, 5, 55, 30, 60, 20, 40};
        int phase_del  [7] = '{15, 80, 15, 40, 10, 50, 30};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_LOOKUP, 5, 64'h0, 0);
        send_word(OP_DELETE, 5, 64'h0, 0);
        send_word(OP_READ_IDX, 0, 64'h0, 0);
        send_word(OP_INSERT, 0, 64'h1234, 0);
        send_word(OP_DELETE, 0, 64'h0, 0);
        send_word(OP_UPDATE, 0, 64'h55, 0);
        send_word(OP_LOOKUP, 0, 64'h0, 0);
        for (int op = FIRST_UNUSED_OP; op <= LAST_UNUSED_OP; op++) begin
            send_word(OP_W'(op), 1, '1, '1);
        end
        send_word(OP_INSERT, '1, '1, '1);
        send_word(OP_INSERT, 1, 64'h0, 0);
        send_word(OP_INSERT, 2, 64'ha5a5_5a5a_0f0f_f0f0, 0);
        send_word(OP_INSERT, 1, 64'hdead_beef_0000_0001, 0);
        send_word(OP_UPDATE, 1, 64'hffff_0000_ffff_0000, 0);
        send_word(OP_LOOKUP, 1, 64'h0, 0);
        send_word(OP_READ_IDX, 0, 64'h0, 0);
        send_word(OP_READ_IDX, 0, 64'h0, 2);
        send_word(OP_READ_IDX, '1, 64'h0, 3);
        send_word(OP_READ_IDX, 0, 64'h0, '1);
        send_word(OP_DELETE, '1, 64'h0, 0);
        send_word(OP_READ_IDX, 0, 64'h0, 0);
        send_word(OP_DELETE, 2, 64'h0, 0);
        send_word(OP_LOOKUP, 2, 64'h0, 0);

        // Fill the table to capacity, then try the full-table cases.
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        while (sb.fill < CAPACITY) begin
            send_word(OP_INSERT, KEY_W'($urandom_range(32'h7fff_ffff, 1)),
                      {$urandom, $urandom}, IDX_W'($urandom));
        end
        send_word(OP_INSERT, 0, 64'h0, 0);
        send_word(OP_INSERT, sb.keys[0], 64'h0, 0);
        send_word(OP_INSERT, 3, 64'h0, 0);
        send_word(OP_READ_IDX, 0, 64'h0, '1);
        send_word(OP_DELETE, sb.keys[CAPACITY-1], 64'h0, 0);
        s_tvalid <= 1'b0;
        wait_all_results();

        for (int p = 0; p < 7; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (p == 4) begin
                hold_len = HOLD_OFF_CYCLES;
            end
            for (int n = 0; n < 180; n++) begin
                send_random(phase_ins[p], phase_del[p]);
            end
            if (p == 1) begin
                s_tvalid <= 1'b0;
                wait_all_results();
            end
        end
        s_tvalid <= 1'b0;

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[keyed_record_table.f]
sv/krt_pkg.sv
sv/krt_engine.sv
sv/keyed_record_table.sv
tb/sv/keyed_record_table_tb.sv
